// ----- hdl/mdsd_pkg.sv -----
package mdsd_pkg;

    // field widths
    localparam int CMD_W  = 16;
    localparam int DUTY_W = 9;
    localparam int PWM_W  = 8;

    // dead band edge of the mapped duty range
    localparam int DEAD_BAND = 90;

    // max_duty after reset
    localparam logic [PWM_W-1:0] MAX_DUTY_RESET = 8'd200;

    // serial multiplier and divider step counts
    localparam int MUL_STEPS = PWM_W;
    localparam int DIV_STEPS = 2 * PWM_W;

endpackage

// ----- hdl/mdsd_if.sv -----
// speed command channel
interface mdsd_cmd_if;
    logic                                valid;
    logic                                ready;
    logic signed [mdsd_pkg::CMD_W-1:0]   speed_command;

    modport source (output valid, output speed_command, input ready);
    modport sink   (input valid, input speed_command, output ready);
endinterface

// duty result channel
interface mdsd_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [mdsd_pkg::DUTY_W-1:0]  applied_duty;
    logic        [mdsd_pkg::PWM_W-1:0]   pwm_forward;
    logic        [mdsd_pkg::PWM_W-1:0]   pwm_reverse;

    modport source (output valid, output applied_duty, output pwm_forward,
                    output pwm_reverse, input ready);
    modport sink   (input valid, input applied_duty, input pwm_forward,
                    input pwm_reverse, output ready);
endinterface

// max_duty register write channel
interface mdsd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic        [mdsd_pkg::PWM_W-1:0]   max_duty;

    modport source (output valid, output max_duty, input ready);
    modport sink   (input valid, input max_duty, output ready);
endinterface

// ----- hdl/motor_duty_slew_deadband_unit.sv -----
// a nonzero command runs through the multiply, divide and finish states; a command that
// saturates to zero goes from idle straight to the finish state
// a new command is taken only in idle, after the last result is loaded; the shared adder does
// 8 shift-add multiply steps and 16 restoring divide steps in turn
// reset (rst_n, asynchronous, active low): previous duty 0, max_duty 200, sequencer idle,
// no result pending
module motor_duty_slew_deadband_unit (
    input  logic        clk,
    input  logic        rst_n,
    mdsd_cmd_if.sink    cmd,
    mdsd_res_if.source  res,
    mdsd_cfg_if.sink    cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    // sequencer and datapath registers
    state_t                             state_reg,     state_next;
    logic [3:0]                         cnt_reg,       cnt_next;
    logic                               pos_reg,       pos_next;
    logic                               neg_reg,       neg_next;
    logic                               negq_reg,      negq_next;
    logic [15:0]                        prod_reg,      prod_next;
    logic [15:0]                        mcand_reg,     mcand_next;
    logic [7:0]                         mplier_reg,    mplier_next;
    logic [8:0]                         rem_reg,       rem_next;
    logic [15:0]                        quo_reg,       quo_next;
    logic signed [mdsd_pkg::DUTY_W-1:0] prev_reg,      prev_next;
    logic [mdsd_pkg::PWM_W-1:0]         max_duty_reg,  max_duty_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    logic signed [mdsd_pkg::DUTY_W-1:0] out_duty_reg,  out_duty_next;
    logic [mdsd_pkg::PWM_W-1:0]         out_fwd_reg,   out_fwd_next;
    logic [mdsd_pkg::PWM_W-1:0]         out_rev_reg,   out_rev_next;

    // input side: saturate the command and set up the interpolation operands
    logic signed [16:0] cmd_ext;
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [16:0] clamp17;
    logic signed [9:0]  clamp10;
    logic [9:0]         k_wide;
    logic [7:0]         k_val;
    logic [7:0]         amag;
    logic [7:0]         divisor;

    // the one shared adder / subtractor
    logic [16:0] alu_a;
    logic [16:0] alu_b;
    logic        alu_sub;
    logic [16:0] alu_res;
    logic [8:0]  trial;

    // finishing arithmetic
    logic signed [10:0] m11;
    logic signed [10:0] q_s;
    logic signed [10:0] interp_val;
    logic signed [10:0] target_clamped;
    logic signed [10:0] target;
    logic signed [10:0] prev11;
    logic signed [10:0] duty11;
    logic               cmd_take;
    logic               out_load;

    assign cmd_take  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign res.valid        = out_valid_reg;
    assign res.applied_duty = out_duty_reg;
    assign res.pwm_forward  = out_fwd_reg;
    assign res.pwm_reverse  = out_rev_reg;

    // saturation to plus or minus max_duty
    assign cmd_ext = {cmd.speed_command[15], cmd.speed_command};
    assign lim_pos = {9'b0, max_duty_reg};
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (cmd_ext >= lim_pos)
        begin
            clamp17 = lim_pos;
        end
        else if (cmd_ext <= lim_neg)
        begin
            clamp17 = lim_neg;
        end
        else
        begin
            clamp17 = cmd_ext;
        end
    end

    assign clamp10 = clamp17[9:0];

    // offset into the input span: value-1 on the forward side, value+max on the reverse
    assign k_wide = (clamp10 > 10'sd0) ? 10'(clamp10 - 10'sd1)
                                       : 10'(clamp10 + $signed({2'b0, max_duty_reg}));
    assign k_val  = k_wide[7:0];

    // output span magnitude |max - dead band|, its sign kept apart
    assign amag = (max_duty_reg >= 8'(mdsd_pkg::DEAD_BAND))
                ? 8'(max_duty_reg - 8'(mdsd_pkg::DEAD_BAND))
                : 8'(8'(mdsd_pkg::DEAD_BAND) - max_duty_reg);

    // input span; an empty span is handled at the end
    assign divisor = 8'(max_duty_reg - 8'd1);

    // shared adder: accumulates partial products, then does trial subtractions
    assign trial = {rem_reg[7:0], quo_reg[15]};

    always_comb
    begin
        case (state_reg)
            ST_DIV:
            begin
                alu_a   = {8'b0, trial};
                alu_b   = {9'b0, divisor};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = {1'b0, prod_reg};
                alu_b   = {1'b0, mcand_reg};
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + {16'b0, alu_sub};

    // final interpolation, second saturation, sign guard and slew
    assign m11 = {3'b0, max_duty_reg};
    assign q_s = negq_reg ? -$signed({3'b0, quo_reg[7:0]}) : $signed({3'b0, quo_reg[7:0]});

    always_comb
    begin
        if (!pos_reg && !neg_reg)
        begin
            interp_val = 11'sd0;
        end
        else if (max_duty_reg == 8'd1)
        begin
            // empty input span: take the lower end of the output span
            interp_val = pos_reg ? 11'(mdsd_pkg::DEAD_BAND) : -11'sd1;
        end
        else if (pos_reg)
        begin
            interp_val = q_s + 11'(mdsd_pkg::DEAD_BAND);
        end
        else
        begin
            interp_val = q_s - m11;
        end
    end

    always_comb
    begin
        if (interp_val >= m11)
        begin
            target_clamped = m11;
        end
        else if (interp_val <= -m11)
        begin
            target_clamped = -m11;
        end
        else
        begin
            target_clamped = interp_val;
        end
    end

    assign prev11 = 11'(prev_reg);

    // a reversal first passes through zero
    assign target = ((prev11 < 11'sd0 && target_clamped > 11'sd0) ||
                     (prev11 > 11'sd0 && target_clamped < 11'sd0))
                  ? 11'sd0 : target_clamped;

    always_comb
    begin
        if (target > prev11 + 11'sd1)
        begin
            duty11 = prev11 + 11'sd1;
        end
        else if (target < prev11 - 11'sd1)
        begin
            duty11 = prev11 - 11'sd1;
        end
        else
        begin
            duty11 = target;
        end
    end

    // result goes out once the output register is free
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || res.ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        negq_next      = negq_reg;
        prod_next      = prod_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        prev_next      = prev_reg;
        max_duty_next  = max_duty_reg;
        out_valid_next = out_valid_reg;
        out_duty_next  = out_duty_reg;
        out_fwd_next   = out_fwd_reg;
        out_rev_next   = out_rev_reg;

        if (cfg.valid && cfg.ready)
        begin
            max_duty_next = cfg.max_duty;
        end

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    pos_next    = (clamp10 > 10'sd0);
                    neg_next    = (clamp10 < 10'sd0);
                    negq_next   = (max_duty_reg < 8'(mdsd_pkg::DEAD_BAND));
                    prod_next   = 16'd0;
                    mcand_next  = {8'b0, k_val};
                    mplier_next = amag;
                    cnt_next    = 4'd0;
                    state_next  = (clamp10 == 10'sd0) ? ST_FINISH : ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add: one multiplier bit a cycle
                if (mplier_reg[0])
                begin
                    prod_next = alu_res[15:0];
                end
                mcand_next  = {mcand_reg[14:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[7:1]};
                cnt_next    = 4'(cnt_reg + 4'd1);
                if (cnt_reg == 4'(mdsd_pkg::MUL_STEPS - 1))
                begin
                    quo_next   = mplier_reg[0] ? alu_res[15:0] : prod_reg;
                    rem_next   = 9'd0;
                    cnt_next   = 4'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division: one quotient bit a cycle
                rem_next = alu_res[16] ? trial : alu_res[8:0];
                quo_next = {quo_reg[14:0], ~alu_res[16]};
                cnt_next = 4'(cnt_reg + 4'd1);
                if (cnt_reg == 4'(mdsd_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    prev_next      = duty11[8:0];
                    out_valid_next = 1'b1;
                    out_duty_next  = duty11[8:0];
                    out_fwd_next   = 8'd0;
                    out_rev_next   = 8'd0;
                    if (duty11 > 11'sd0)
                    begin
                        out_fwd_next = (duty11 > m11) ? max_duty_reg : duty11[7:0];
                    end
                    else if (duty11 < 11'sd0)
                    begin
                        out_rev_next = (-duty11 > m11) ? max_duty_reg : 8'(-duty11);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 4'd0;
            pos_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            negq_reg      <= 1'b0;
            prod_reg      <= 16'd0;
            mcand_reg     <= 16'd0;
            mplier_reg    <= 8'd0;
            rem_reg       <= 9'd0;
            quo_reg       <= 16'd0;
            prev_reg      <= '0;
            max_duty_reg  <= mdsd_pkg::MAX_DUTY_RESET;
            out_valid_reg <= 1'b0;
            out_duty_reg  <= '0;
            out_fwd_reg   <= '0;
            out_rev_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            neg_reg       <= neg_next;
            negq_reg      <= negq_next;
            prod_reg      <= prod_next;
            mcand_reg     <= mcand_next;
            mplier_reg    <= mplier_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            prev_reg      <= prev_next;
            max_duty_reg  <= max_duty_next;
            out_valid_reg <= out_valid_next;
            out_duty_reg  <= out_duty_next;
            out_fwd_reg   <= out_fwd_next;
            out_rev_reg   <= out_rev_next;
        end
    end

`ifndef NO_ASSERTIONS
    // duty never moves more than one step per transaction
    a_slew_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> ((duty11 - prev11) == 11'sd1 || (duty11 - prev11) == 11'sd0 ||
                      (duty11 - prev11) == -11'sd1))
        else $error("duty slewed by more than one step");

    // both bridge legs never driven at once
    a_legs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.pwm_forward == 8'd0 || res.pwm_reverse == 8'd0))
        else $error("forward and reverse legs both driven");

    // forward level only with a positive duty, reverse only with a negative one
    a_leg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ((res.pwm_forward == 8'd0 || res.applied_duty > 9'sd0) &&
                       (res.pwm_reverse == 8'd0 || res.applied_duty < 9'sd0)))
        else $error("bridge leg level disagrees with duty sign");

    // the stored duty follows each delivered result
    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (prev_reg == res.applied_duty && res.valid))
        else $error("previous duty does not match the result");
`endif

endmodule
